// ===== design/urrb_pkg.sv =====
`timescale 1ns / 1ps

package urrb_pkg;

	localparam int DEPTH = 64;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int BYTE_W = 8;
	localparam int TIMER_W = 16;
	localparam int COUNT_OUT_W = 7;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [TIMER_W-1:0] TIMEOUT_RST = TIMER_W'(50);
	localparam logic [TIMER_W-1:0] ELAPSED_MAX = '1;

	localparam logic [ADDR_W-1:0] REG_IDLE_TIMEOUT = ADDR_W'(0);

	typedef enum logic [1:0] {
		KIND_RECEIVE = 2'd0,
		KIND_POP     = 2'd1,
		KIND_TICK    = 2'd2,
		KIND_CLEAR   = 2'd3
	} kind_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} store_req_t;

	function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

endpackage

// ===== design/urrb_store.sv =====
`timescale 1ns / 1ps

module urrb_store (
	input  logic                       clk,
	input  urrb_pkg::store_req_t       req,
	output logic [urrb_pkg::BYTE_W-1:0] rd_data
);
	import urrb_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/urrb_ctrl.sv =====
`timescale 1ns / 1ps

module urrb_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [urrb_pkg::BYTE_W-1:0]       rx_byte,
	input  logic [urrb_pkg::TIMER_W-1:0]      timeout,
	output urrb_pkg::store_req_t              store_req,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              pop_ok,
	output logic                              pop_empty,
	output logic                              dropped,
	output logic [urrb_pkg::COUNT_OUT_W-1:0]  byte_count,
	output logic                              is_full,
	output logic                              reception_done
);
	import urrb_pkg::*;

	logic [PTR_W-1:0]   wptr_q, wptr_d;
	logic [PTR_W-1:0]   rptr_q, rptr_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [TIMER_W-1:0] elapsed_q, elapsed_d;

	logic out_valid_q;
	logic pop_ok_q, pop_empty_q, dropped_q, is_full_q, done_q;
	logic [COUNT_OUT_W-1:0] byte_count_q;

	logic accept;
	logic full, empty;
	logic pop_ok_d, pop_empty_d, dropped_d;
	kind_t kind_e;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign kind_e   = kind_t'(kind);
	assign full     = (count_q >= CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		wptr_d      = wptr_q;
		rptr_d      = rptr_q;
		count_d     = count_q;
		elapsed_d   = elapsed_q;
		pop_ok_d    = 1'b0;
		pop_empty_d = 1'b0;
		dropped_d   = 1'b0;
		store_req.we    = 1'b0;
		store_req.waddr = wptr_q;
		store_req.wdata = rx_byte;
		store_req.re    = 1'b0;
		store_req.raddr = rptr_q;
		case (kind_e)
			KIND_RECEIVE: begin
				if (full) begin
					dropped_d = 1'b1;
				end else begin
					elapsed_d    = '0;
					count_d      = count_q + CNT_W'(1);
					wptr_d       = ptr_advance(wptr_q);
					store_req.we = accept;
				end
			end
			KIND_POP: begin
				if (empty) begin
					pop_empty_d = 1'b1;
				end else begin
					pop_ok_d     = 1'b1;
					count_d      = count_q - CNT_W'(1);
					rptr_d       = ptr_advance(rptr_q);
					store_req.re = accept;
				end
			end
			KIND_TICK: begin
				if (elapsed_q != ELAPSED_MAX) begin
					elapsed_d = elapsed_q + TIMER_W'(1);
				end
			end
			KIND_CLEAR: begin
				wptr_d  = '0;
				rptr_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			rptr_q      <= '0;
			count_q     <= '0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				wptr_q    <= wptr_d;
				rptr_q    <= rptr_d;
				count_q   <= count_d;
				elapsed_q <= elapsed_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_q     <= pop_ok_d;
			pop_empty_q  <= pop_empty_d;
			dropped_q    <= dropped_d;
			byte_count_q <= COUNT_OUT_W'(count_d);
			is_full_q    <= (count_d >= CNT_W'(DEPTH));
			done_q       <= (elapsed_d >= timeout);
		end
	end

	assign out_valid      = out_valid_q;
	assign pop_ok         = pop_ok_q;
	assign pop_empty      = pop_empty_q;
	assign dropped        = dropped_q;
	assign byte_count     = byte_count_q;
	assign is_full        = is_full_q;
	assign reception_done = done_q;

endmodule

// ===== design/uart_rx_ring_buffer_idle_timeout.sv =====
// The result of an accepted item is registered on the output register.
// Throughput: one item per cycle; a new item is taken whenever the output
// register is empty or is being taken in the same cycle.
// Reset (arst_n low, asynchronous): pointers, count, idle timer and output valid
// clear; idle timeout register loads 50. Byte store contents are not reset.
`timescale 1ns / 1ps

module uart_rx_ring_buffer_idle_timeout (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [urrb_pkg::ADDR_W-1:0]          paddr,
	input  logic [urrb_pkg::DATA_W-1:0]          pwdata,
	output logic [urrb_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic [urrb_pkg::BYTE_W-1:0]          rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [urrb_pkg::BYTE_W-1:0]          popped_byte,
	output logic                                 pop_empty,
	output logic                                 dropped,
	output logic [urrb_pkg::COUNT_OUT_W-1:0]     byte_count,
	output logic                                 is_full,
	output logic                                 reception_done
);
	import urrb_pkg::*;

	logic [TIMER_W-1:0] timeout_q;
	logic               cfg_wr;
	logic               sel_timeout;
	store_req_t         store_req;
	logic [BYTE_W-1:0]  rd_data;
	logic               pop_ok;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// registers are word aligned, the low two address bits are ignored
	assign sel_timeout = (paddr[ADDR_W-1:2] == REG_IDLE_TIMEOUT[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr && sel_timeout) begin
			timeout_q <= pwdata[TIMER_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_timeout) begin
			prdata = DATA_W'(timeout_q);
		end
	end

	urrb_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.timeout        (timeout_q),
		.store_req      (store_req),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pop_ok         (pop_ok),
		.pop_empty      (pop_empty),
		.dropped        (dropped),
		.byte_count     (byte_count),
		.is_full        (is_full),
		.reception_done (reception_done)
	);

	urrb_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (rd_data)
	);

	assign popped_byte = pop_ok ? rd_data : '0;

endmodule

// ===== design/urrb_chk.sv =====
`timescale 1ns / 1ps

module urrb_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [urrb_pkg::BYTE_W-1:0]       popped_byte,
	input logic                              pop_empty,
	input logic                              dropped,
	input logic [urrb_pkg::COUNT_OUT_W-1:0]  byte_count,
	input logic                              is_full
);
	import urrb_pkg::*;

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted item produced no result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pop_empty) |-> (byte_count == '0 && popped_byte == '0 && !dropped))
		else $error("empty pop with data or count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped) |-> is_full)
		else $error("drop while not full");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_full == (byte_count == COUNT_OUT_W'(DEPTH))))
		else $error("full flag disagrees with count");

endmodule

bind uart_rx_ring_buffer_idle_timeout urrb_chk u_urrb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.popped_byte (popped_byte),
	.pop_empty   (pop_empty),
	.dropped     (dropped),
	.byte_count  (byte_count),
	.is_full     (is_full)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import urrb_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		kind_t             op;
		logic [BYTE_W-1:0] data;
	} rx_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]      popped;
		logic                   empty;
		logic                   drop;
		logic [COUNT_OUT_W-1:0] count;
		logic                   full;
		logic                   done;
	} rx_status_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [DATA_W-1:0]      pwdata = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [1:0]             kind = KIND_RECEIVE;
	logic [BYTE_W-1:0]      rx_byte = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [BYTE_W-1:0]      popped_byte;
	logic                   pop_empty;
	logic                   dropped;
	logic [COUNT_OUT_W-1:0] byte_count;
	logic                   is_full;
	logic                   reception_done;

	rx_item_t   pending_items[$];
	rx_status_t status_due[$];

	logic [BYTE_W-1:0] shadow_bytes [DEPTH];
	int shadow_wr = 0;
	int shadow_rd = 0;
	int shadow_held = 0;
	int shadow_idle = 0;
	int shadow_timeout = TIMEOUT_RST;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   errors = 0;
	int   cycles = 0;
	logic in_fire = 1'b0;

	uart_rx_ring_buffer_idle_timeout i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.popped_byte    (popped_byte),
		.pop_empty      (pop_empty),
		.dropped        (dropped),
		.byte_count     (byte_count),
		.is_full        (is_full),
		.reception_done (reception_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rx_status_t buffer_step(rx_item_t it);
		rx_status_t s;
		s = '0;
		case (it.op)
			KIND_RECEIVE: begin
				if (shadow_held >= DEPTH) begin
					s.drop = 1'b1;
				end else begin
					shadow_idle = 0;
					shadow_bytes[shadow_wr] = it.data;
					shadow_held++;
					shadow_wr = (shadow_wr == DEPTH - 1) ? 0 : shadow_wr + 1;
				end
			end
			KIND_POP: begin
				if (shadow_held == 0) begin
					s.empty = 1'b1;
				end else begin
					s.popped = shadow_bytes[shadow_rd];
					shadow_held--;
					shadow_rd = (shadow_rd == DEPTH - 1) ? 0 : shadow_rd + 1;
				end
			end
			KIND_TICK: begin
				if (shadow_idle < ELAPSED_MAX)
					shadow_idle++;
			end
			default: begin
				shadow_wr = 0;
				shadow_rd = 0;
				shadow_held = 0;
			end
		endcase
		s.count = COUNT_OUT_W'(shadow_held);
		s.full = (shadow_held >= DEPTH);
		s.done = (shadow_idle >= shadow_timeout);
		return s;
	endfunction

	task automatic report(string what, int got, int want);
		$display("t=%0t %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	// driver: may offer a new item whenever the slot is empty or was just taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				kind <= pending_items[0].op;
				rx_byte <= pending_items[0].data;
				pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// monitor and predictor
	always @(posedge clk) begin
		rx_status_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("uart_rx_ring_buffer_idle_timeout: mismatch");
			$finish;
		end else begin
			in_fire <= arst_n && in_valid && in_stall === 1'b0;
			if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
				if (status_due.size() == 0) begin
					report("unexpected item, byte_count", byte_count, -1);
				end else begin
					want = status_due.pop_front();
					if (popped_byte !== want.popped)
						report("popped_byte", popped_byte, want.popped);
					if (pop_empty !== want.empty)
						report("pop_empty", pop_empty, want.empty);
					if (dropped !== want.drop)
						report("dropped", dropped, want.drop);
					if (byte_count !== want.count)
						report("byte_count", byte_count, want.count);
					if (is_full !== want.full)
						report("is_full", is_full, want.full);
					if (reception_done !== want.done)
						report("reception_done", reception_done, want.done);
				end
			end
			if (arst_n && in_valid && in_stall === 1'b0)
				status_due.push_back(buffer_step('{kind_t'(kind), rx_byte}));
		end
	end

	task automatic push_item(kind_t op, int data);
		pending_items.push_back('{op, BYTE_W'(data)});
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || status_due.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_timeout(int value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = REG_IDLE_TIMEOUT;
		pwdata = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		shadow_timeout = value & 16'hFFFF;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (prdata[TIMER_W-1:0] !== TIMER_W'(value))
			report("idle timeout readback", prdata[TIMER_W-1:0], value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// mostly bursts that fill, drain and time out the buffer, plus noise
	task automatic add_random(int n);
		int made;
		int len;
		int r;
		made = 0;
		while (made < n) begin
			r = $urandom_range(99);
			if (r < 18) begin
				len = $urandom_range(1, 72);
				repeat (len) push_item(KIND_RECEIVE, $urandom_range(255));
			end else if (r < 34) begin
				len = $urandom_range(1, 70);
				repeat (len) push_item(KIND_POP, $urandom_range(255));
			end else if (r < 46) begin
				len = $urandom_range(1, (shadow_timeout + 3 < 80) ? shadow_timeout + 3 : 80);
				repeat (len) push_item(KIND_TICK, $urandom_range(255));
			end else if (r < 50) begin
				len = 1;
				push_item(KIND_CLEAR, $urandom_range(255));
			end else begin
				len = 1;
				push_item(kind_t'($urandom_range(3)), $urandom_range(255));
			end
			made += len;
		end
	endtask

	initial begin
		int timeouts [6];
		timeouts = '{50, 1, 65535, 3, 0, 17};
		timeouts[4] = $urandom_range(1, 40);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty, clear, wrap of byte values, reset timeout
		push_item(KIND_POP, 8'h33);
		push_item(KIND_CLEAR, 8'h00);
		push_item(KIND_TICK, 8'hFF);
		push_item(KIND_RECEIVE, 8'h00);
		push_item(KIND_RECEIVE, 8'hFF);
		push_item(KIND_TICK, 8'h12);
		push_item(KIND_POP, 8'h00);
		push_item(KIND_RECEIVE, 8'h80);
		push_item(KIND_RECEIVE, 8'h01);
		push_item(KIND_POP, 8'hFF);
		push_item(KIND_POP, 8'h00);
		push_item(KIND_POP, 8'h00);
		push_item(KIND_POP, 8'h00);
		push_item(KIND_RECEIVE, 8'h7F);
		push_item(KIND_CLEAR, 8'hFF);
		push_item(KIND_POP, 8'h00);
		push_item(KIND_RECEIVE, 8'hAA);
		push_item(KIND_POP, 8'h55);
		wait_idle();
		set_timeout(1);
		push_item(KIND_TICK, 8'h00);
		push_item(KIND_RECEIVE, 8'h55);
		push_item(KIND_TICK, 8'h00);
		push_item(KIND_POP, 8'h00);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			send_idle_pct = (p < 2) ? 8 : (p < 4) ? 82 : 0;
			recv_idle_pct = (p < 2) ? 82 : (p < 4) ? 8 : 0;
			set_timeout(timeouts[p]);
			add_random(170);
			wait_idle();
		end

		set_timeout(TIMEOUT_RST);
		add_random(40);
		wait_idle();

		if (errors == 0 && status_due.size() == 0) begin
			$display("uart_rx_ring_buffer_idle_timeout: match");
		end else begin
			$display("uart_rx_ring_buffer_idle_timeout: mismatch");
		end
		$finish;
	end

endmodule
